/* rtl/dnsa_pkg.sv */
`default_nettype none

package dnsa_pkg;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned CountW    = 16;
  localparam int unsigned AnsW      = 4;
  localparam int unsigned AddrW     = 32;
  localparam int unsigned ShiftW    = 24;
  localparam int unsigned OutDataW  = ((AddrW + AnsW + 7) / 8) * 8;

  localparam logic [CountW-1:0] HeaderBytes   = CountW'(12);
  localparam logic [CountW-1:0] QtailBytes    = CountW'(4);
  localparam logic [CountW-1:0] AnsFixedBytes = CountW'(10);
  localparam logic [CountW-1:0] RdlenBytes    = CountW'(2);
  localparam logic [CountW-1:0] Ipv4Bytes     = CountW'(4);
  localparam logic [AnsW-1:0]   AnsMax        = '1;
  localparam logic [AnsW-1:0]   MaxAnswersRst = AnsW'(2);

  typedef enum logic [2:0] {
    PhHeader,
    PhQlen,
    PhQlabel,
    PhQtail,
    PhAfixed,
    PhRdlen,
    PhRdata,
    PhIgnore
  } phase_e;

  // one parser result, present only when has_result is set
  typedef struct packed {
    logic             has_result;
    logic             addr_valid;
    logic [AddrW-1:0] address;
    logic [AnsW-1:0]  answer_index;
    logic             end_of_message;
  } result_t;

endpackage

`default_nettype wire

/* rtl/dnsa_parser.sv */
`default_nettype none

module dnsa_parser (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          step_i,
  input  wire  [dnsa_pkg::ByteW-1:0]   data_byte_i,
  input  wire                          last_byte_i,
  input  wire  [dnsa_pkg::AnsW-1:0]    max_answers_i,
  output dnsa_pkg::result_t            result_o
);
  import dnsa_pkg::*;

  phase_e            phase_q, phase_d;
  logic [CountW-1:0] cnt_q, cnt_d;
  logic [CountW-1:0] rdlen_q, rdlen_d;
  logic [ShiftW-1:0] shift_q, shift_d;
  logic [AnsW-1:0]   ans_q, ans_d;

  logic [CountW-1:0] cnt_dec;
  logic [CountW-1:0] rdlen_new;
  logic [AnsW-1:0]   ans_inc;

  assign cnt_dec   = cnt_q - CountW'(1);
  assign rdlen_new = {rdlen_q[CountW-ByteW-1:0], data_byte_i};
  assign ans_inc   = (ans_q == AnsMax) ? ans_q : ans_q + AnsW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHeader;
      cnt_q   <= HeaderBytes;
      rdlen_q <= '0;
      shift_q <= '0;
      ans_q   <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      rdlen_q <= rdlen_d;
      shift_q <= shift_d;
      ans_q   <= ans_d;
    end
  end

  always_comb begin
    phase_d  = phase_q;
    cnt_d    = cnt_q;
    rdlen_d  = rdlen_q;
    shift_d  = shift_q;
    ans_d    = ans_q;
    result_o = '0;

    case (phase_q)
      PhHeader, PhQlabel: begin
        cnt_d = cnt_dec;
        if (cnt_dec == '0) begin
          phase_d = PhQlen;
        end
      end
      PhQlen: begin
        if (data_byte_i == '0) begin
          phase_d = PhQtail;
          cnt_d   = QtailBytes;
        end else begin
          phase_d = PhQlabel;
          cnt_d   = CountW'(data_byte_i);
        end
      end
      PhQtail: begin
        cnt_d = cnt_dec;
        if (cnt_dec == '0) begin
          if (ans_q < max_answers_i) begin
            phase_d = PhAfixed;
            cnt_d   = AnsFixedBytes;
          end else begin
            phase_d = PhIgnore;
            cnt_d   = '0;
          end
        end
      end
      PhAfixed: begin
        cnt_d = cnt_dec;
        if (cnt_dec == '0) begin
          phase_d = PhRdlen;
          cnt_d   = RdlenBytes;
          rdlen_d = '0;
        end
      end
      PhRdlen: begin
        rdlen_d = rdlen_new;
        cnt_d   = cnt_dec;
        if (cnt_dec == '0) begin
          shift_d = '0;
          if (rdlen_new == '0) begin
            ans_d = ans_inc;
            if (ans_inc < max_answers_i) begin
              phase_d = PhAfixed;
              cnt_d   = AnsFixedBytes;
            end else begin
              phase_d = PhIgnore;
              cnt_d   = '0;
            end
          end else begin
            phase_d = PhRdata;
            cnt_d   = rdlen_new;
          end
        end
      end
      PhRdata: begin
        if (rdlen_q == Ipv4Bytes) begin
          if (cnt_q == CountW'(1)) begin
            result_o.addr_valid   = 1'b1;
            result_o.address      = {shift_q, data_byte_i};
            result_o.answer_index = ans_q;
          end
          shift_d = {shift_q[ShiftW-ByteW-1:0], data_byte_i};
        end
        cnt_d = cnt_dec;
        if (cnt_dec == '0) begin
          ans_d = ans_inc;
          if (ans_inc < max_answers_i) begin
            phase_d = PhAfixed;
            cnt_d   = AnsFixedBytes;
          end else begin
            phase_d = PhIgnore;
            cnt_d   = '0;
          end
        end
      end
      default: ;
    endcase

    // end of message returns the parser to its starting point
    if (last_byte_i) begin
      phase_d = PhHeader;
      cnt_d   = HeaderBytes;
      rdlen_d = '0;
      shift_d = '0;
      ans_d   = '0;
    end

    result_o.end_of_message = last_byte_i;
    result_o.has_result     = result_o.addr_valid | last_byte_i;
  end

endmodule

`default_nettype wire

/* rtl/dns_answer_ipv4_extractor_unit.sv */
`default_nettype none

// path: an accepted input item passes the input register and the parser; a result goes via the result register
// throughput: one byte item per cycle while no result waits on a held result register, set by the
// parser update between the input register and the result register
// reset: asynchronous, active low; parser to header skip, max_answers to 2,
// both registers emptied
module dns_answer_ipv4_extractor_unit (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  // configuration: max_answers
  input  wire                              cfg_we_i,
  input  wire  [dnsa_pkg::AnsW-1:0]        cfg_wdata_i,
  // input byte stream
  input  wire                              s_tvalid_i,
  output logic                             s_tready_o,
  input  wire  [dnsa_pkg::ByteW-1:0]       s_tdata_i,   // [7:0] data_byte
  input  wire                              s_tlast_i,   // last_byte
  // result stream
  output logic                             m_tvalid_o,
  input  wire                              m_tready_i,
  output logic [dnsa_pkg::OutDataW-1:0]    m_tdata_o,   // [31:0] address, [35:32] answer_index
  output logic                             m_tuser_o,   // addr_valid
  output logic                             m_tlast_o    // end_of_message
);
  import dnsa_pkg::*;

  logic [AnsW-1:0]  max_answers_q;

  // input register
  logic             in_valid_q;
  logic [ByteW-1:0] in_byte_q;
  logic             in_last_q;

  // result register
  logic             out_valid_q;
  logic             out_addr_valid_q;
  logic [AddrW-1:0] out_address_q;
  logic [AnsW-1:0]  out_index_q;
  logic             out_eom_q;

  result_t          res;
  logic             step;
  logic             s_accept;

  // an item moves on unless it has a result and the result register is still held
  assign step       = in_valid_q & (~res.has_result | ~out_valid_q | m_tready_i);
  assign s_tready_o = ~in_valid_q | step;
  assign s_accept   = s_tvalid_i & s_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_answers_q <= MaxAnswersRst;
    end else if (cfg_we_i) begin
      max_answers_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_tready_o) begin
      in_valid_q <= s_tvalid_i;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_byte_q <= s_tdata_i;
      in_last_q <= s_tlast_i;
    end
  end

  dnsa_parser u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (step),
    .data_byte_i   (in_byte_q),
    .last_byte_i   (in_last_q),
    .max_answers_i (max_answers_q),
    .result_o      (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step & res.has_result) begin
      out_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step & res.has_result) begin
      out_addr_valid_q <= res.addr_valid;
      out_address_q    <= res.address;
      out_index_q      <= res.answer_index;
      out_eom_q        <= res.end_of_message;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = OutDataW'({out_index_q, out_address_q});
  assign m_tuser_o  = out_addr_valid_q;
  assign m_tlast_o  = out_eom_q;

endmodule

`default_nettype wire
